// ----- src/bcs_pkg.sv -----
package bcs_pkg;

   // Sequencer states: load, rank, suppress, find last, emit
   typedef enum logic [4:0] {
      S_LOAD,
      S_RK_RDI,
      S_RK_WI,
      S_RK_RDJ,
      S_RK_WJ,
      S_RK_CJ,
      S_RK_WR,
      S_SP_RA,
      S_SP_BA,
      S_SP_LA,
      S_SP_RB,
      S_SP_BB,
      S_SP_LB,
      S_SP_T0,
      S_SP_T1,
      S_SP_T2,
      S_SP_NB,
      S_SP_NEXT,
      S_LS_RD,
      S_LS_CK,
      S_OUT_RD,
      S_OUT_CK,
      S_OUT_SEND
   } state_type;

endpackage

// ----- src/bcs_ram.sv -----
module bcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one entry, register the read data
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/bcs_overlap.sv -----
module bcs_overlap #(
   parameter int COORD_BITS = 10
) (
   input  logic                    clock,
   input  logic [4*COORD_BITS-1:0] big_box,
   input  logic [4*COORD_BITS-1:0] small_box,
   output logic                    suppress
);

   localparam int C = COORD_BITS;

   logic [C-1:0]   bx, by, bw, bh, sx, sy, sw, sh;
   logic [C:0]     bx2, by2, sx2, sy2, x1, y1, x2, y2;
   logic [C:0]     dx_in, dy_in, dx_ff, dy_ff;
   logic           hit_in, hit_ff;
   logic [2*C-1:0] area_in, area_ff;
   logic [2*C+1:0] inter;
   logic           sup_in, sup_ff;

   assign {bx, by, bw, bh} = big_box;
   assign {sx, sy, sw, sh} = small_box;

   // Stage 1: intersection extents and area of the smaller-ranked box
   always_comb begin
      bx2     = {1'b0, bx} + {1'b0, bw};
      by2     = {1'b0, by} + {1'b0, bh};
      sx2     = {1'b0, sx} + {1'b0, sw};
      sy2     = {1'b0, sy} + {1'b0, sh};
      x1      = (bx > sx) ? {1'b0, bx} : {1'b0, sx};
      y1      = (by > sy) ? {1'b0, by} : {1'b0, sy};
      x2      = (bx2 < sx2) ? bx2 : sx2;
      y2      = (by2 < sy2) ? by2 : sy2;
      dx_in   = x2 - x1;
      dy_in   = y2 - y1;
      hit_in  = (x2 > x1) && (y2 > y1);
      area_in = sw * sh;
   end

   // Stage 2: twice the intersection against the area
   always_comb begin
      inter  = dx_ff * dy_ff;
      sup_in = hit_ff && ({inter, 1'b0} > {3'b000, area_ff});
   end

   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      hit_ff  <= hit_in;
      area_ff <= area_in;
      sup_ff  <= sup_in;
   end

   assign suppress = sup_ff;

endmodule

// ----- src/box_containment_suppression.sv -----
// Loading: one box per cycle, a new box every cycle while the set is open.
// Pass after the final box, n boxes stored: ranking, then suppression, then the
// last-keep sweep, then emit, in which rsp_ready may hold each result back;
// all phases share the single read port of the box memory.
// The first result comes only after ranking, suppression and the sweep.
// Synchronous reset clears the control state; the memories are not cleared.
module box_containment_suppression #(
   parameter int MAX_BOXES  = 64,
   parameter int COORD_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_box_x,
   input  logic [COORD_BITS-1:0] req_box_y,
   input  logic [COORD_BITS-1:0] req_box_width,
   input  logic [COORD_BITS-1:0] req_box_height,
   input  logic                  req_final_box,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_kept_x,
   output logic [COORD_BITS-1:0] rsp_kept_y,
   output logic [COORD_BITS-1:0] rsp_kept_width,
   output logic [COORD_BITS-1:0] rsp_kept_height,
   output logic                  rsp_end_of_run,
   output logic                  rsp_overflowed
);

   import bcs_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int BW = 4 * C + 1;
   localparam int IW = $clog2(MAX_BOXES);
   localparam int CW = $clog2(MAX_BOXES + 1);
   localparam logic [CW-1:0] MaxCount = CW'(MAX_BOXES);

   state_type state_ff, state_in;

   logic [CW-1:0]  count_ff, count_in;
   logic           ovf_ff, ovf_in;
   logic [CW-1:0]  n_ff, n_in;
   logic [CW-1:0]  i_ff, i_in, j_ff, j_in, rnk_ff, rnk_in;
   logic [2*C-1:0] area_i_ff, area_i_in, area_j_ff, area_j_in;
   logic [BW-1:0]  box_a_ff, box_a_in, box_b_ff, box_b_in;
   logic [IW-1:0]  b_idx_ff, b_idx_in, last_ff, last_in;
   logic [C-1:0]   out_x_ff, out_y_ff, out_w_ff, out_h_ff;
   logic [C-1:0]   out_x_in, out_y_in, out_w_in, out_h_in;
   logic           out_end_ff, out_end_in;

   logic           box_we;
   logic [IW-1:0]  box_waddr, box_raddr;
   logic [BW-1:0]  box_wdata, box_rdata;
   logic           rank_we;
   logic [IW-1:0]  rank_waddr, rank_raddr, rank_rdata;
   logic [2*C-1:0] rd_area;
   logic           suppress;
   logic [CW-1:0]  n_last;
   logic           i_end, j_end;

   bcs_ram #(.WIDTH(BW), .DEPTH(MAX_BOXES)) u_box_ram (
      .clock (clock),
      .we    (box_we),
      .waddr (box_waddr),
      .wdata (box_wdata),
      .raddr (box_raddr),
      .rdata (box_rdata)
   );

   bcs_ram #(.WIDTH(IW), .DEPTH(MAX_BOXES)) u_rank_ram (
      .clock (clock),
      .we    (rank_we),
      .waddr (rank_waddr),
      .wdata (i_ff[IW-1:0]),
      .raddr (rank_raddr),
      .rdata (rank_rdata)
   );

   bcs_overlap #(.COORD_BITS(C)) u_overlap (
      .clock     (clock),
      .big_box   (box_a_ff[4*C-1:0]),
      .small_box (box_b_ff[4*C-1:0]),
      .suppress  (suppress)
   );

   assign rd_area = box_rdata[2*C-1:C] * box_rdata[C-1:0];
   assign n_last  = n_ff - CW'(1);
   assign i_end   = (i_ff == n_last);
   assign j_end   = (j_ff == n_last);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD:     if (req_valid && req_final_box) state_in = S_RK_RDI;
         S_RK_RDI:   state_in = S_RK_WI;
         S_RK_WI:    state_in = S_RK_RDJ;
         S_RK_RDJ:   state_in = S_RK_WJ;
         S_RK_WJ:    state_in = S_RK_CJ;
         S_RK_CJ:    state_in = j_end ? S_RK_WR : S_RK_RDJ;
         S_RK_WR:    state_in = i_end ? S_SP_RA : S_RK_RDI;
         S_SP_RA:    state_in = S_SP_BA;
         S_SP_BA:    state_in = S_SP_LA;
         S_SP_LA:    state_in = (!box_rdata[4*C] || i_end) ? S_SP_NEXT : S_SP_RB;
         S_SP_RB:    state_in = S_SP_BB;
         S_SP_BB:    state_in = S_SP_LB;
         S_SP_LB:    state_in = box_rdata[4*C] ? S_SP_T0 : S_SP_NB;
         S_SP_T0:    state_in = S_SP_T1;
         S_SP_T1:    state_in = S_SP_T2;
         S_SP_T2:    state_in = S_SP_NB;
         S_SP_NB:    state_in = j_end ? S_SP_NEXT : S_SP_RB;
         S_SP_NEXT:  state_in = i_end ? S_LS_RD : S_SP_RA;
         S_LS_RD:    state_in = S_LS_CK;
         S_LS_CK:    state_in = i_end ? S_OUT_RD : S_LS_RD;
         S_OUT_RD:   state_in = S_OUT_CK;
         S_OUT_CK: begin
            if (box_rdata[4*C]) state_in = S_OUT_SEND;
            else if (i_end)     state_in = S_LOAD;
            else                state_in = S_OUT_RD;
         end
         S_OUT_SEND: if (rsp_ready) state_in = i_end ? S_LOAD : S_OUT_RD;
         default:    state_in = S_LOAD;
      endcase
   end

   // Datapath, counters and memory ports
   always_comb begin
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      n_in       = n_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      rnk_in     = rnk_ff;
      area_i_in  = area_i_ff;
      area_j_in  = area_j_ff;
      box_a_in   = box_a_ff;
      box_b_in   = box_b_ff;
      b_idx_in   = b_idx_ff;
      last_in    = last_ff;
      out_x_in   = out_x_ff;
      out_y_in   = out_y_ff;
      out_w_in   = out_w_ff;
      out_h_in   = out_h_ff;
      out_end_in = out_end_ff;
      box_we     = 1'b0;
      box_waddr  = count_ff[IW-1:0];
      box_wdata  = {1'b1, req_box_x, req_box_y, req_box_width, req_box_height};
      box_raddr  = i_ff[IW-1:0];
      rank_we    = 1'b0;
      rank_waddr = rnk_ff[IW-1:0];
      rank_raddr = i_ff[IW-1:0];
      case (state_ff)
         // Store the box with its keep flag set, or mark the drop
         S_LOAD: begin
            if (req_valid) begin
               if (count_ff < MaxCount) begin
                  box_we   = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               n_in = (count_ff < MaxCount) ? count_ff + CW'(1) : count_ff;
               i_in = '0;
            end
         end
         S_RK_RDI: box_raddr = i_ff[IW-1:0];
         S_RK_WI: begin
            area_i_in = rd_area;
            j_in      = '0;
            rnk_in    = '0;
         end
         S_RK_RDJ: box_raddr = j_ff[IW-1:0];
         S_RK_WJ:  area_j_in = rd_area;
         // Count boxes ranked ahead of box i
         S_RK_CJ: begin
            if ((area_j_ff > area_i_ff) || ((area_j_ff == area_i_ff) && (j_ff < i_ff))) begin
               rnk_in = rnk_ff + CW'(1);
            end
            j_in = j_ff + CW'(1);
         end
         S_RK_WR: begin
            rank_we = 1'b1;
            i_in    = i_end ? '0 : i_ff + CW'(1);
         end
         S_SP_RA: rank_raddr = i_ff[IW-1:0];
         S_SP_BA: box_raddr = rank_rdata;
         S_SP_LA: begin
            box_a_in = box_rdata;
            j_in     = i_ff + CW'(1);
         end
         S_SP_RB: rank_raddr = j_ff[IW-1:0];
         S_SP_BB: begin
            box_raddr = rank_rdata;
            b_idx_in  = rank_rdata;
         end
         S_SP_LB: box_b_in = box_rdata;
         // Clear the keep flag of a suppressed box
         S_SP_T2: begin
            box_waddr = b_idx_ff;
            box_wdata = {1'b0, box_b_ff[4*C-1:0]};
            box_we    = suppress;
         end
         S_SP_NB: j_in = j_ff + CW'(1);
         S_SP_NEXT: i_in = i_end ? '0 : i_ff + CW'(1);
         S_LS_RD: box_raddr = i_ff[IW-1:0];
         S_LS_CK: begin
            if (box_rdata[4*C]) last_in = i_ff[IW-1:0];
            i_in = i_end ? '0 : i_ff + CW'(1);
         end
         S_OUT_RD: box_raddr = i_ff[IW-1:0];
         // Capture a kept box into the result register
         S_OUT_CK: begin
            {out_x_in, out_y_in, out_w_in, out_h_in} = box_rdata[4*C-1:0];
            out_end_in = (i_ff[IW-1:0] == last_ff);
            if (!box_rdata[4*C]) begin
               if (i_end) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  i_in = i_ff + CW'(1);
               end
            end
         end
         S_OUT_SEND: begin
            if (rsp_ready) begin
               if (i_end) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  i_in = i_ff + CW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      rnk_ff     <= rnk_in;
      area_i_ff  <= area_i_in;
      area_j_ff  <= area_j_in;
      box_a_ff   <= box_a_in;
      box_b_ff   <= box_b_in;
      b_idx_ff   <= b_idx_in;
      last_ff    <= last_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_w_ff   <= out_w_in;
      out_h_ff   <= out_h_in;
      out_end_ff <= out_end_in;
   end

   assign req_ready       = (state_ff == S_LOAD);
   assign rsp_valid       = (state_ff == S_OUT_SEND);
   assign rsp_kept_x      = out_x_ff;
   assign rsp_kept_y      = out_y_ff;
   assign rsp_kept_width  = out_w_ff;
   assign rsp_kept_height = out_h_ff;
   assign rsp_end_of_run  = out_end_ff;
   assign rsp_overflowed  = ovf_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MaxCount) else $error("box count beyond capacity");

   a_box_write_phase: assert property (@(posedge clock) disable iff (reset)
      box_we |-> (state_ff == S_LOAD || state_ff == S_SP_T2))
      else $error("box memory written outside load or suppression");

   a_set_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD) |-> (n_ff != '0)) else $error("pass started on empty set");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && i_end) |=> (count_ff == '0 && !ovf_ff))
      else $error("set state not cleared after last result");
`endif

endmodule
